[hw/rtl/lavr_pkg.sv]
// Shared types and constants for the lattice average velocity block.
`default_nettype none
package lavr_pkg;
	localparam int SPEED_W = 16;
	localparam int HEIGHT_W = 13;
	localparam int VISC_W = 16;
	localparam int AVG_W = 20;
	localparam int RE_W = 32;
	localparam int COUNT_W = 21;
	localparam int SUM_W = 41;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_CELLS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_RHO = 2'd2;

	localparam logic REG_HEIGHT = 1'b0;
	localparam logic REG_VISC = 1'b1;

	// One classified cell passed from the front end to the back end.
	typedef struct packed {
		logic        open;
		logic        zero_rho;
		logic        last;
		logic [AVG_W-1:0] mag;
	} cell_t;
endpackage
`default_nettype wire

[hw/rtl/lavr_divu.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module lavr_divu #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW+1:0] trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign trial = {1'b0, shifted} - {2'b00, den_q};

	// Shift in one numerator bit and try a subtract each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

[hw/rtl/lavr_isqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module lavr_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [33:0] val,
	output logic             done,
	output logic [16:0]      root
);
	logic [33:0] v_q;
	logic [35:0] rem_q;
	logic [16:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] shifted;
	logic [35:0] trial;

	assign shifted = {rem_q[33:0], v_q[33:32]};
	assign trial = shifted - {17'd0, root_q, 2'b01};

	// Two radicand bits per step, one root bit per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			v_q <= val;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[31:0], 2'b00};
			if (!trial[35]) begin
				rem_q <= trial;
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q <= shifted;
				root_q <= {root_q[15:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

[hw/rtl/lavr_front.sv]
// Front end: takes a cell, works out density, components and magnitude.
`default_nettype none
module lavr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [143:0]  speeds,
	input  wire logic          is_obstacle,
	input  wire logic          last_cell,
	output logic               out_valid,
	input  wire logic          out_ready,
	output lavr_pkg::cell_t    out_cell
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIVX = 3'd1;
	localparam logic [2:0] S_DIVY = 3'd2;
	localparam logic [2:0] S_SQ = 3'd3;
	localparam logic [2:0] S_ROOT = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0]  state_q;
	logic [19:0] rho_q;
	logic [17:0] dx_q, dy_q;
	logic [34:0] ux_q, uy_q;
	logic [33:0] sq_q;
	logic        open_q, zero_q, last_q;
	logic [19:0] mag_q;
	logic [19:0] rho_c;
	logic [17:0] px, nx, py, ny;
	logic [15:0] f [9];
	logic        div_start, div_busy, div_done;
	logic [34:0] div_num, div_quo;
	logic        sq_start, sq_done;
	logic [16:0] sq_root;
	logic [33:0] ux_sq, uy_sq;
	logic [34:0] sumsq;

	always_comb begin
		for (int k = 0; k < 9; k++) f[k] = speeds[k*16 +: 16];
		rho_c = '0;
		for (int k = 0; k < 9; k++) rho_c = rho_c + 20'(f[k]);
		px = 18'(f[1]) + 18'(f[5]) + 18'(f[8]);
		nx = 18'(f[3]) + 18'(f[6]) + 18'(f[7]);
		py = 18'(f[2]) + 18'(f[5]) + 18'(f[6]);
		ny = 18'(f[4]) + 18'(f[7]) + 18'(f[8]);
	end

	assign in_ready = (state_q == S_IDLE);
	assign div_start = (state_q == S_DIVX || state_q == S_DIVY) && !div_busy && !div_done;
	assign div_num = (state_q == S_DIVX) ? {dx_q, 17'd0} >> 1 : {dy_q, 17'd0} >> 1;
	// Each component is at most 2^16, so 17-bit squares suffice and the sum fits 34 bits.
	assign ux_sq = {17'd0, ux_q[16:0]} * {17'd0, ux_q[16:0]};
	assign uy_sq = {17'd0, uy_q[16:0]} * {17'd0, uy_q[16:0]};
	assign sumsq = {1'b0, ux_sq} + {1'b0, uy_sq};
	assign sq_start = (state_q == S_ROOT) && !sq_done;

	lavr_divu #(.NW(35), .DW(20)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(rho_q),
		.busy(div_busy), .done(div_done), .quo(div_quo));

	lavr_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(sq_q),
		.done(sq_done), .root(sq_root));

	// Per-cell sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					if (is_obstacle || rho_c == '0) state_q <= S_OUT;
					else state_q <= S_DIVX;
				end
				S_DIVX: if (div_done) state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_SQ;
				S_SQ: state_q <= S_ROOT;
				S_ROOT: if (sq_done) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rho_q <= rho_c;
				dx_q <= (px >= nx) ? px - nx : nx - px;
				dy_q <= (py >= ny) ? py - ny : ny - py;
				open_q <= !is_obstacle;
				zero_q <= (rho_c == '0);
				last_q <= last_cell;
				mag_q <= '0;
			end
			S_DIVX: if (div_done) ux_q <= div_quo;
			S_DIVY: if (div_done) uy_q <= div_quo;
			S_SQ: sq_q <= sumsq[34] ? '1 : sumsq[33:0];
			S_ROOT: if (sq_done) mag_q <= 20'(sq_root);
			default: ;
		endcase
	end

	assign out_valid = (state_q == S_OUT);
	assign out_cell = '{open: open_q, zero_rho: zero_q, last: last_q, mag: mag_q};
endmodule
`default_nettype wire

[hw/rtl/lavr_queue.sv]
// Two-entry queue between the front and back ends.
`default_nettype none
module lavr_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_valid,
	output logic             wr_ready,
	input  lavr_pkg::cell_t  wr_data,
	output logic             rd_valid,
	input  wire logic        rd_ready,
	output lavr_pkg::cell_t  rd_data
);
	lavr_pkg::cell_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

[hw/rtl/lavr_back.sv]
// Back end: accumulates magnitudes and forms the mean and Reynolds number.
`default_nettype none
module lavr_back #(
	parameter int MAX_CELLS = 1048576
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [12:0] grid_height,
	input  wire logic [15:0] viscosity,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  lavr_pkg::cell_t  in_cell,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [19:0]      average_velocity,
	output logic [31:0]      reynolds_number,
	output logic [20:0]      open_cell_count,
	output logic [1:0]       status
);
	localparam logic [2:0] B_ACC = 3'd0;
	localparam logic [2:0] B_DAVG = 3'd1;
	localparam logic [2:0] B_MUL = 3'd2;
	localparam logic [2:0] B_DRE = 3'd3;
	localparam logic [2:0] B_OUT = 3'd4;
	localparam logic [40:0] SUM_MAX = '1;

	logic [2:0]  state_q;
	logic [40:0] sum_q;
	logic [20:0] cnt_q;
	logic        zero_q;
	logic [19:0] avg_q;
	logic [32:0] prod_q;
	logic [41:0] sum_next;
	logic        take;
	logic        d_start, d_busy, d_done;
	logic [48:0] d_num, d_quo;
	logic [20:0] d_den;

	assign in_ready = (state_q == B_ACC);
	assign take = in_valid && in_ready;
	assign sum_next = {1'b0, sum_q} + 42'(in_cell.mag);
	assign d_start = (state_q == B_DAVG || state_q == B_DRE) && !d_busy && !d_done;
	assign d_num = (state_q == B_DAVG) ? 49'(sum_q) : {prod_q, 16'd0};
	assign d_den = (state_q == B_DAVG) ? cnt_q : 21'(viscosity);

	lavr_divu #(.NW(49), .DW(21)) u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .num(d_num), .den(d_den),
		.busy(d_busy), .done(d_done), .quo(d_quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_ACC;
			sum_q <= '0;
			cnt_q <= '0;
			zero_q <= 1'b0;
		end else begin
			case (state_q)
				B_ACC: if (take) begin
					if (in_cell.open && 32'(cnt_q) < MAX_CELLS) begin
						sum_q <= sum_next[41] ? SUM_MAX : sum_next[40:0];
						cnt_q <= cnt_q + 1'b1;
						if (in_cell.zero_rho) zero_q <= 1'b1;
						if (in_cell.last) state_q <= B_DAVG;
					end else if (in_cell.last) begin
						state_q <= (cnt_q == '0) ? B_OUT : B_DAVG;
					end
				end
				B_DAVG: if (d_done) state_q <= B_MUL;
				B_MUL: state_q <= (prod_q == '0 || viscosity == '0) ? B_OUT : B_DRE;
				B_DRE: if (d_done) state_q <= B_OUT;
				B_OUT: if (out_ready) begin
					state_q <= B_ACC;
					sum_q <= '0;
					cnt_q <= '0;
					zero_q <= 1'b0;
				end
				default: state_q <= B_ACC;
			endcase
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			B_ACC: begin
				avg_q <= '0;
				reynolds_number <= '0;
			end
			B_DAVG: if (d_done) begin
				avg_q <= (d_quo[48:20] != '0) ? 20'hFFFFF : d_quo[19:0];
				prod_q <= 33'(((d_quo[48:20] != '0) ? 20'hFFFFF : d_quo[19:0])) *
					33'(grid_height);
			end
			B_MUL: if (prod_q == '0) reynolds_number <= '0;
				else if (viscosity == '0) reynolds_number <= '1;
			B_DRE: if (d_done) reynolds_number <= (d_quo[48:32] != '0) ? '1 : d_quo[31:0];
			default: ;
		endcase
	end

	assign out_valid = (state_q == B_OUT);
	assign average_velocity = avg_q;
	assign open_cell_count = cnt_q;
	assign status = (cnt_q == '0) ? lavr_pkg::ST_NO_CELLS :
		zero_q ? lavr_pkg::ST_ZERO_RHO : lavr_pkg::ST_OK;

	a_sum_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_CELLS) else $error("cell count past limit");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cnt_q))
		else $error("result changed while stalled");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_ACC |-> !in_ready) else $error("cell taken while finishing");
endmodule
`default_nettype wire

[hw/rtl/lattice_average_velocity_reynolds.sv]
// Top level of the D2Q9 average velocity and Reynolds number block.
// Cells arrive on the s_axis channel, one per transfer: nine distribution
// values in tdata, is_obstacle in tuser and last_cell in tlast. Results leave
// on m_axis, one per grid, on the transfer that follows the last cell.
// An open cell passes the front end through two serial divides for the velocity
// components and a serial square root; obstacle and zero-density cells skip them.
// The back end adds each open cell to the sum as it is taken; on the last cell it
// runs a mean divide, a multiply by grid_height and a Reynolds divide, but skips
// both divides if no cell was counted, the last for a zero product or viscosity.
// A two-entry queue lets the front end work on the next cell while the back
// end waits. If the receiver stalls, the result holds and the queue fills,
// then s_axis_tready drops. Reset clears the sums, count and flag and loads
// grid_height 128 and viscosity 1311. Configuration writes are taken at any
// edge with cfg_we high, and should be made only while the block is idle.
`default_nettype none
module lattice_average_velocity_reynolds #(
	parameter int MAX_CELLS = 1048576
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// speed_rest, east, north, west, south, northeast, northwest, southwest, southeast
	input  wire logic [143:0] s_axis_tdata,
	// is_obstacle
	input  wire logic         s_axis_tuser,
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// average_velocity, reynolds_number, open_cell_count, status, zero fill
	output logic [79:0]       m_axis_tdata
);
	logic [12:0] height_q;
	logic [15:0] visc_q;
	logic f_valid, f_ready, b_valid, b_ready;
	lavr_pkg::cell_t f_cell, b_cell;
	logic [19:0] avg;
	logic [31:0] re;
	logic [20:0] cnt;
	logic [1:0]  st;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 13'd128;
			visc_q <= 16'd1311;
		end else if (cfg_we) begin
			if (cfg_index == lavr_pkg::REG_HEIGHT) height_q <= cfg_data[12:0];
			else visc_q <= cfg_data;
		end
	end

	lavr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.speeds(s_axis_tdata), .is_obstacle(s_axis_tuser), .last_cell(s_axis_tlast),
		.out_valid(f_valid), .out_ready(f_ready), .out_cell(f_cell));

	lavr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_cell), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cell));

	lavr_back #(.MAX_CELLS(MAX_CELLS)) u_back (
		.clk(clk), .arst_n(arst_n), .grid_height(height_q), .viscosity(visc_q),
		.in_valid(b_valid), .in_ready(b_ready), .in_cell(b_cell),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.average_velocity(avg), .reynolds_number(re), .open_cell_count(cnt), .status(st));

	assign m_axis_tdata = {5'd0, st, cnt, re, avg};
endmodule
`default_nettype wire
